FILE: rtl/stroke_stamp_generator_top_macros.svh
// Assertion macros for the stroke stamp generator
`ifndef STROKE_STAMP_GENERATOR_TOP_MACROS_SVH
`define STROKE_STAMP_GENERATOR_TOP_MACROS_SVH
`define SSG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg
// Types and constants shared by the stroke stamp generator.
// ----------------------------------------------------------------------------
package ssg_pkg;
    localparam logic [2:0] MODE_PENCIL  = 3'd0;
    localparam logic [2:0] MODE_BRUSH   = 3'd1;
    localparam logic [2:0] MODE_FILL    = 3'd2;
    localparam logic [2:0] MODE_RAINBOW = 3'd3;
    localparam logic [2:0] MODE_DITHER  = 3'd4;
    localparam logic [2:0] MODE_STICKER = 3'd5;
    localparam logic [2:0] MODE_SPARE6  = 3'd6;
    localparam logic [2:0] MODE_SPARE7  = 3'd7;

    localparam logic [2:0] KIND_CIRCLE  = 3'd0;
    localparam logic [2:0] KIND_SQUARE  = 3'd1;
    localparam logic [2:0] KIND_DITHER  = 3'd2;
    localparam logic [2:0] KIND_CLEAR   = 3'd3;
    localparam logic [2:0] KIND_TEST    = 3'd4;

    localparam logic [1:0] REG_TOOL   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_COLOR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SQRT, ST_NGO, ST_DIV,
        ST_XGO, ST_OFFX, ST_YGO, ST_OFFY, ST_EMIT
    } state_t;

    function automatic logic [3:0] rainbow_color(input logic [2:0] p);
        case (p)
            3'd0: rainbow_color = 4'd3;
            3'd1: rainbow_color = 4'd7;
            3'd2: rainbow_color = 4'd8;
            3'd3: rainbow_color = 4'd10;
            3'd4: rainbow_color = 4'd14;
            3'd5: rainbow_color = 4'd13;
            3'd6: rainbow_color = 4'd4;
            default: rainbow_color = 4'd3;
        endcase
    endfunction
endpackage

FILE: rtl/stroke_stamp_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stroke_stamp_generator_top
// Turns a touch tick into a run of brush stamps along the stroke.
// ----------------------------------------------------------------------------
// One tick is taken at a time; s_tready is low while a tick is worked on and
// while a result beat waits. A line tick is accepted, its squared length is
// formed, its bit-pair square root is taken, and the root is divided by the
// step, where the shared divider width is DW = COORD_WIDTH+log2(MAX_STAMPS)+1
// (17 by default). Each of its n+1 stamps then takes two divisions and one
// output step, which waits while a result beat is held. Fill and sticker give
// their beat in the cycle after the accept; gated and undefined-tool ticks are
// ready again on the next cycle.
module stroke_stamp_generator_top import ssg_pkg::*; #(
    parameter int MAX_STAMPS  = 64,
    parameter int COORD_WIDTH = 10
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    // canvas_shown, touch_pressed, touch_x, touch_y, prev_x, prev_y; zero pad
    input  logic [((4*COORD_WIDTH+2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // stamp_x, stamp_y, stamp_kind, color_index, steps_capped; zero pad
    output logic [((2*COORD_WIDTH+8+7)/8)*8-1:0] m_tdata,
    output logic m_tlast
);
    localparam int CW = COORD_WIDTH;
    localparam int NW = $clog2(MAX_STAMPS);
    localparam int DW = CW + NW + 1;
    localparam int VW = 2 * CW + 2;
    localparam int OW = ((2*CW+8+7)/8)*8;

    state_t state_reg, state_next;
    logic [2:0] tool_reg;
    logic [6:0] rad_reg;
    logic [3:0] dcol_reg;
    logic pb_reg;
    logic [2:0] rb_reg, rb_next;
    logic [CW-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic [CW-1:0] adx_reg, adx_next, ady_reg, ady_next;
    logic xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [2:0] kind_reg, kind_next;
    logic [VW-1:0] v_reg, v_next, root_reg, root_next, bit_reg, bit_next;
    logic [NW-1:0] n_reg, n_next, i_reg, i_next;
    logic cap_reg, cap_next;
    logic [DW-1:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [CW-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [2:0] okind_reg, okind_next;
    logic [3:0] ocol_reg, ocol_next;
    logic olast_reg, olast_next, ocap_reg, ocap_next;
    logic ov_reg, ov_next;
    logic dstart, ddone;
    logic [DW-1:0] dvd, dvs, dq;
    logic shown, pressed;
    logic [CW-1:0] tx, ty, px, py, sel_x, sel_y;
    logic [CW:0] diff_x, diff_y, neg_x, neg_y;
    logic [2*CW-1:0] sqx, sqy;
    logic [VW:0] trial;
    logic [DW-1:0] step, den, num_x, num_y;
    logic [2:0] rb_pos;

    assign shown   = s_tdata[0];
    assign pressed = s_tdata[1];
    assign tx = s_tdata[2+:CW];
    assign ty = s_tdata[2+CW+:CW];
    assign px = s_tdata[2+2*CW+:CW];
    assign py = s_tdata[2+3*CW+:CW];

    assign sel_x  = pb_reg ? px : tx;
    assign sel_y  = pb_reg ? py : ty;
    assign diff_x = {1'b0, tx} - {1'b0, sel_x};
    assign diff_y = {1'b0, ty} - {1'b0, sel_y};
    assign neg_x  = '0 - diff_x;
    assign neg_y  = '0 - diff_y;

    assign sqx   = adx_reg * adx_reg;
    assign sqy   = ady_reg * ady_reg;
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign step  = (rad_reg[6:1] == 6'd0) ? DW'(1) : DW'(rad_reg[6:1]);
    assign den   = (n_reg == '0) ? DW'(1) : DW'({n_reg, 1'b0});
    assign num_x = xneg_reg ? ((accx_reg >= DW'(n_reg)) ? accx_reg - DW'(n_reg) : '0)
                            : accx_reg + DW'(n_reg);
    assign num_y = yneg_reg ? ((accy_reg >= DW'(n_reg)) ? accy_reg - DW'(n_reg) : '0)
                            : accy_reg + DW'(n_reg);
    assign rb_pos = (rb_reg == 3'd7) ? 3'd0 : rb_reg;

    ssg_divider #(.W(DW)) u_div (
        .aclk, .aresetn, .start(dstart), .dividend(dvd), .divisor(dvs),
        .done(ddone), .quotient(dq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tool_reg <= MODE_BRUSH; rad_reg <= 7'd5; dcol_reg <= 4'd3;
            pb_reg <= 1'b0; rb_reg <= '0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rb_reg <= rb_next;
            ov_reg <= ov_next;
            if (s_tvalid && s_tready) begin
                pb_reg <= pressed;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOOL:   tool_reg <= cfg_data[2:0];
                    REG_RADIUS: rad_reg  <= cfg_data;
                    REG_COLOR:  dcol_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        x0_reg <= x0_next; y0_reg <= y0_next;
        adx_reg <= adx_next; ady_reg <= ady_next;
        xneg_reg <= xneg_next; yneg_reg <= yneg_next; kind_reg <= kind_next;
        v_reg <= v_next; root_reg <= root_next; bit_reg <= bit_next;
        n_reg <= n_next; i_reg <= i_next; cap_reg <= cap_next;
        accx_reg <= accx_next; accy_reg <= accy_next;
        ox_reg <= ox_next; oy_reg <= oy_next;
        sx_reg <= sx_next; sy_reg <= sy_next; okind_reg <= okind_next;
        ocol_reg <= ocol_next; olast_reg <= olast_next; ocap_reg <= ocap_next;
    end

    always_comb begin
        state_next = state_reg;
        x0_next = x0_reg; y0_next = y0_reg;
        adx_next = adx_reg; ady_next = ady_reg;
        xneg_next = xneg_reg; yneg_next = yneg_reg; kind_next = kind_reg;
        v_next = v_reg; root_next = root_reg; bit_next = bit_reg;
        n_next = n_reg; i_next = i_reg; cap_next = cap_reg;
        accx_next = accx_reg; accy_next = accy_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        sx_next = sx_reg; sy_next = sy_reg; okind_next = okind_reg;
        ocol_next = ocol_reg; olast_next = olast_reg; ocap_next = ocap_reg;
        ov_next = ov_reg; rb_next = rb_reg;
        dstart = 1'b0; dvd = '0; dvs = DW'(1);
        s_tready = (state_reg == ST_IDLE) && !ov_reg;
        if (ov_reg && m_tready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) begin
                x0_next = sel_x; y0_next = sel_y;
                xneg_next = diff_x[CW]; yneg_next = diff_y[CW];
                adx_next = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
                ady_next = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
                kind_next = (tool_reg == MODE_PENCIL) ? KIND_SQUARE :
                            (tool_reg == MODE_DITHER) ? KIND_DITHER : KIND_CIRCLE;
                if (shown && pressed) begin
                    if (tool_reg == MODE_FILL || tool_reg == MODE_STICKER) begin
                        ov_next = 1'b1; sx_next = '0; sy_next = '0;
                        okind_next = (tool_reg == MODE_FILL) ? KIND_CLEAR : KIND_TEST;
                        ocol_next = (tool_reg == MODE_FILL) ? dcol_reg : 4'd0;
                        olast_next = 1'b1; ocap_next = 1'b0;
                    end else if (tool_reg <= MODE_DITHER) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                v_next = VW'(sqx) + VW'(sqy);
                root_next = '0;
                bit_next = VW'(1) << (2*CW);
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if ({1'b0, v_reg} >= trial) begin
                    v_next = v_reg - trial[VW-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == VW'(1)) state_next = ST_NGO;
            end
            ST_NGO: begin
                dstart = 1'b1;
                dvd = DW'(root_reg);
                dvs = step;
                state_next = ST_DIV;
            end
            ST_DIV: if (ddone) begin
                if (dq > DW'(MAX_STAMPS - 1)) begin
                    n_next = NW'(MAX_STAMPS - 1); cap_next = 1'b1;
                end else begin
                    n_next = dq[NW-1:0]; cap_next = 1'b0;
                end
                i_next = '0; accx_next = '0; accy_next = '0;
                state_next = ST_XGO;
            end
            ST_XGO: begin
                dstart = 1'b1; dvd = num_x; dvs = den;
                state_next = ST_OFFX;
            end
            ST_OFFX: if (ddone) begin
                ox_next = xneg_reg ? x0_reg - dq[CW-1:0] : x0_reg + dq[CW-1:0];
                state_next = ST_YGO;
            end
            ST_YGO: begin
                dstart = 1'b1; dvd = num_y; dvs = den;
                state_next = ST_OFFY;
            end
            ST_OFFY: if (ddone) begin
                oy_next = yneg_reg ? y0_reg - dq[CW-1:0] : y0_reg + dq[CW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: if (!ov_reg || m_tready) begin
                ov_next = 1'b1;
                sx_next = ox_reg; sy_next = oy_reg; okind_next = kind_reg;
                ocol_next = (tool_reg == MODE_RAINBOW) ? rainbow_color(rb_pos) : dcol_reg;
                if (tool_reg == MODE_RAINBOW)
                    rb_next = (rb_pos == 3'd6) ? 3'd0 : rb_pos + 3'd1;
                olast_next = (i_reg == n_reg); ocap_next = cap_reg;
                if (i_reg == n_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    i_next = i_reg + 1'b1;
                    accx_next = accx_reg + DW'({adx_reg, 1'b0});
                    accy_next = accy_reg + DW'({ady_reg, 1'b0});
                    state_next = ST_XGO;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = OW'({ocap_reg, ocol_reg, okind_reg, sy_reg, sx_reg});
endmodule

FILE: rtl/ssg_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssg_divider import ssg_pkg::*; #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  rem_reg, rem_next, quo_reg, quo_next, dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end else begin
            done = 1'b0;
        end
        if (busy_reg && cnt_reg == CW'(1)) begin
            done = 1'b1;
        end
    end

    assign quotient = quo_next;
endmodule

FILE: rtl/ssg_checker.sv
`timescale 1ns / 1ps
`include "stroke_stamp_generator_top_macros.svh"
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks for the stroke stamp generator.
// ----------------------------------------------------------------------------
module ssg_checker import ssg_pkg::*; #(
    parameter int OW = 32
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [OW-1:0] m_tdata,
    input logic          m_tlast
);
    `SSG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `SSG_ASSERT_IMPL(a_no_take_busy, m_tvalid, !s_tready)
    `SSG_ASSERT_IMPL(a_ctrl_known, 1'b1, !$isunknown(m_tvalid) && !$isunknown(s_tready))
endmodule

bind stroke_stamp_generator_top ssg_checker #(.OW($bits(m_tdata))) u_ssg_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

FILE: tb/tb_stroke_stamp_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stroke_stamp_generator_top
// Checks the stroke stamp generator against a behavioral prediction of the
// stamps along each stroke. Directed ticks cover every tool, gating, radius
// and coordinate extremes, and count saturation. Random strokes follow, under
// bursty input, a stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [9:0] sx;
    logic [9:0] sy;
    logic [2:0] kind;
    logic [3:0] color;
    logic       last;
    logic       capped;
} stamp_t;

class stamp_scoreboard;
    stamp_t     pending[$];
    int         errors;
    logic [2:0] tool;
    logic [6:0] radius;
    logic [3:0] color;
    logic       was_pressed;
    logic [2:0] rb_pos;

    function new();
        errors = 0;
        tool = ssg_pkg::MODE_BRUSH;
        radius = 7'd5;
        color = 4'd3;
        was_pressed = 1'b0;
        rb_pos = 3'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
        if (idx == ssg_pkg::REG_TOOL) tool = val[2:0];
        else if (idx == ssg_pkg::REG_RADIUS) radius = val;
        else if (idx == ssg_pkg::REG_COLOR) color = val[3:0];
    endfunction

    function longint isqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function void note_tick(logic [47:0] d);
        logic   shown, pressed;
        longint x1, y1, x0, y0, dx, dy, n, stp, ox, oy;
        logic   capped;
        logic [2:0] kind, p;
        stamp_t e;
        shown = d[0];
        pressed = d[1];
        x1 = longint'(d[11:2]);
        y1 = longint'(d[21:12]);
        x0 = was_pressed ? longint'(d[31:22]) : x1;
        y0 = was_pressed ? longint'(d[41:32]) : y1;
        was_pressed = pressed;
        if (!shown || !pressed) return;
        if (tool == ssg_pkg::MODE_FILL) begin
            e = '{10'd0, 10'd0, ssg_pkg::KIND_CLEAR, color, 1'b1, 1'b0};
            pending.push_back(e);
            return;
        end
        if (tool == ssg_pkg::MODE_STICKER) begin
            e = '{10'd0, 10'd0, ssg_pkg::KIND_TEST, 4'd0, 1'b1, 1'b0};
            pending.push_back(e);
            return;
        end
        if (tool > ssg_pkg::MODE_STICKER) return;
        dx = x1 - x0;
        dy = y1 - y0;
        stp = longint'(radius) / 2;
        if (stp < 1) stp = 1;
        n = isqrt(dx * dx + dy * dy) / stp;
        capped = 1'b0;
        if (n + 1 > 64) begin
            n = 63;
            capped = 1'b1;
        end
        kind = (tool == ssg_pkg::MODE_PENCIL) ? ssg_pkg::KIND_SQUARE :
               (tool == ssg_pkg::MODE_DITHER) ? ssg_pkg::KIND_DITHER :
               ssg_pkg::KIND_CIRCLE;
        for (longint i = 0; i <= n; i++) begin
            ox = (n == 0) ? 0 : (2 * dx * i + n) / (2 * n);
            oy = (n == 0) ? 0 : (2 * dy * i + n) / (2 * n);
            e.sx = 10'(x0 + ox);
            e.sy = 10'(y0 + oy);
            e.kind = kind;
            e.color = color;
            if (tool == ssg_pkg::MODE_RAINBOW) begin
                p = (rb_pos < 7) ? rb_pos : 3'd0;
                case (p)
                    3'd0: e.color = 4'd3;
                    3'd1: e.color = 4'd7;
                    3'd2: e.color = 4'd8;
                    3'd3: e.color = 4'd10;
                    3'd4: e.color = 4'd14;
                    3'd5: e.color = 4'd13;
                    default: e.color = 4'd4;
                endcase
                rb_pos = (p == 3'd6) ? 3'd0 : p + 3'd1;
            end
            e.last = (i == n);
            e.capped = capped;
            pending.push_back(e);
        end
    endfunction

    function void check_stamp(logic [31:0] d, logic last);
        stamp_t e, a;
        a = '{d[9:0], d[19:10], d[22:20], d[26:23], last, d[27]};
        if (pending.size() == 0) begin
            $display("%0t: unexpected stamp %h", $realtime, a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a !== e) begin
            $display("%0t: mismatch expected x=%0d y=%0d kind=%0d color=%0d last=%0b cap=%0b",
                     $realtime, e.sx, e.sy, e.kind, e.color, e.last, e.capped);
            $display("%0t:            actual x=%0d y=%0d kind=%0d color=%0d last=%0b cap=%0b",
                     $realtime, a.sx, a.sy, a.kind, a.color, a.last, a.capped);
            errors++;
        end
    endfunction
endclass

module tb_stroke_stamp_generator_top import ssg_pkg::*;;

    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    stamp_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    int  burst_left = 0;
    bit  hold_req = 0;
    logic [9:0] lx = '0, ly = '0;

    stroke_stamp_generator_top dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_stroke_stamp_generator_top: errors");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_stamp(m_tdata, m_tlast);

    initial begin
        bit held;
        int mode;
        held = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 2);
            repeat (64) begin
                @(posedge aclk);
                if (hold_req && !held) begin
                    held = 1;
                    m_tready <= 1'b0;
                    repeat (4000) @(posedge aclk);
                end
                m_tready <= (mode == 0) ? 1'b1 :
                            (mode == 1) ? ($urandom_range(0, 3) != 0) :
                            ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic configure(logic [2:0] tool, logic [6:0] rad, logic [3:0] col);
        cfg_we <= 1'b1; cfg_index <= REG_TOOL; cfg_data <= {4'd0, tool};
        @(posedge aclk);
        sb.set_reg(REG_TOOL, {4'd0, tool});
        cfg_index <= REG_RADIUS; cfg_data <= rad;
        @(posedge aclk);
        sb.set_reg(REG_RADIUS, rad);
        cfg_index <= REG_COLOR; cfg_data <= {3'd0, col};
        @(posedge aclk);
        sb.set_reg(REG_COLOR, {3'd0, col});
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(logic shown, logic pressed, logic [9:0] x, logic [9:0] y,
                             logic [9:0] px, logic [9:0] py);
        logic [47:0] d;
        d = {6'd0, py, px, y, x, pressed, shown};
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(d);
        sent++;
        lx = x;
        ly = y;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_tick();
        int r;
        logic [9:0] nx, ny;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            nx = lx + 10'($urandom_range(0, 40)) - 10'd20;
            ny = ly + 10'($urandom_range(0, 40)) - 10'd20;
            send_tick(1'b1, 1'b1, nx, ny, lx, ly);
        end else if (r < 88) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
        end else begin
            send_tick(1'b1, 1'b1, 10'($urandom), 10'($urandom), 10'($urandom),
                      10'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: brush, radius 5, color 3
        send_tick(1'b1, 1'b1, 10'd100, 10'd100, 10'd0, 10'd0);
        send_tick(1'b1, 1'b1, 10'd130, 10'd140, 10'd100, 10'd100);
        send_tick(1'b0, 1'b1, 10'd500, 10'd500, 10'd130, 10'd140);
        send_tick(1'b1, 1'b1, 10'd510, 10'd490, 10'd500, 10'd500);
        send_tick(1'b1, 1'b0, 10'd0, 10'd0, 10'd510, 10'd490);
        drain();

        configure(MODE_PENCIL, 7'd1, 4'd0);
        send_tick(1'b1, 1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023);
        send_tick(1'b1, 1'b1, 10'd1023, 10'd1023, 10'd0, 10'd0);
        send_tick(1'b1, 1'b1, 10'd1023, 10'd0, 10'd1023, 10'd1023);
        drain();
        configure(MODE_RAINBOW, 7'd0, 4'd15);
        send_tick(1'b1, 1'b1, 10'd5, 10'd5, 10'd0, 10'd0);
        send_tick(1'b1, 1'b1, 10'd0, 10'd9, 10'd5, 10'd5);
        send_tick(1'b1, 1'b1, 10'd0, 10'd9, 10'd0, 10'd9);
        drain();
        configure(MODE_DITHER, 7'd100, 4'd9);
        send_tick(1'b1, 1'b1, 10'd0, 10'd1023, 10'd1023, 10'd0);
        send_tick(1'b1, 1'b1, 10'd800, 10'd200, 10'd0, 10'd1023);
        drain();
        configure(MODE_FILL, 7'd3, 4'd12);
        send_tick(1'b1, 1'b1, 10'd7, 10'd8, 10'd9, 10'd10);
        send_tick(1'b0, 1'b0, 10'd7, 10'd8, 10'd9, 10'd10);
        drain();
        configure(MODE_STICKER, 7'd2, 4'd5);
        send_tick(1'b1, 1'b1, 10'd7, 10'd8, 10'd9, 10'd10);
        drain();
        configure(MODE_SPARE6, 7'd4, 4'd5);
        send_tick(1'b1, 1'b1, 10'd7, 10'd8, 10'd9, 10'd10);
        drain();
        configure(MODE_SPARE7, 7'd4, 4'd5);
        send_tick(1'b1, 1'b1, 10'd70, 10'd80, 10'd9, 10'd10);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            configure((ph < 6) ? 3'(ph) : 3'($urandom_range(0, 7)),
                      (ph == 0) ? 7'd127 : (ph == 1) ? 7'd0 : 7'($urandom_range(1, 100)),
                      4'($urandom_range(0, 15)));
            for (int k = 0; k < 14; k++) begin
                if (ph == 3 && k == 2) hold_req = 1;
                random_tick();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_stroke_stamp_generator_top: clean");
        end else begin
            $display("tb_stroke_stamp_generator_top: errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ssg_pkg.sv
rtl/ssg_divider.sv
rtl/stroke_stamp_generator_top.sv
rtl/ssg_checker.sv
tb/tb_stroke_stamp_generator_top.sv
